// ----- design/bpeg_pkg.sv -----
// Shared types and constants for the bit packer with Exp-Golomb coding.
`timescale 1ns / 1ps

package bpeg_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_FIXED = 2'd0,
        MODE_UE    = 2'd1,
        MODE_FLUSH = 2'd2
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_BAD  = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    // Largest legal ue value (2^32 - 2)
    localparam logic [63:0] UE_MAX_VALUE = 64'h0000_0000_FFFF_FFFE;

    // Packer state carried from word to word
    typedef struct packed {
        logic [7:0]  partial;  // pending bits, left aligned
        logic [2:0]  fill;     // number of pending bits
        logic [31:0] done;     // bytes emitted so far
    } t_pack_state;

    // Result burst of one input word: up to eight bytes, first byte on top
    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;    // bytes in the burst, 0 means status only
        t_status     status;
    } t_burst;

endpackage

// ----- design/bpeg_encode.sv -----
// Single-pass encoder: turns one input word and the packer state into a byte burst.
`timescale 1ns / 1ps

module bpeg_encode #(
    parameter int MAX_WIDTH = 64
) (
    input  logic [1:0]           i_mode,
    input  logic [63:0]          i_value,
    input  logic [7:0]           i_width,
    input  logic [31:0]          i_cap,
    input  bpeg_pkg::t_pack_state i_state,
    output bpeg_pkg::t_pack_state o_state,
    output bpeg_pkg::t_burst     o_burst
);

    localparam logic [7:0] MaxW = 8'(MAX_WIDTH);

    logic             full;
    logic [31:0]      rem;
    logic [3:0]       rem_c;
    logic [31:0]      code;
    logic [5:0]       ue_len;
    logic             wr;
    logic [6:0]       nbits;
    logic [63:0]      vbits;
    bpeg_pkg::t_status stat;
    logic [6:0]       tot;
    logic [3:0]       tot_bytes;
    logic             trunc;
    logic [3:0]       emit;
    logic [6:0]       shamt;
    logic [71:0]      win;
    logic [71:0]      win_left;

    // Room left before capacity, clipped: nine or more bytes never truncate
    assign full  = i_state.done >= i_cap;
    assign rem   = i_cap - i_state.done;
    assign rem_c = (rem > 32'd8) ? 4'd9 : rem[3:0];

    // ue code number and its bit length
    assign code = i_value[31:0] + 32'd1;
    always_comb begin
        ue_len = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (code[i]) begin
                ue_len = 6'(i + 1);
            end
        end
    end

    // Mode decode: what to write and the status when nothing is written
    always_comb begin
        wr    = 1'b0;
        nbits = 7'd0;
        vbits = 64'd0;
        stat  = bpeg_pkg::STAT_OK;
        case (bpeg_pkg::t_mode'(i_mode))
            bpeg_pkg::MODE_FIXED: begin
                if (full) begin
                    stat = bpeg_pkg::STAT_FULL;
                end else if (i_width == 8'd0 || i_width > MaxW || i_width > 8'd64) begin
                    stat = bpeg_pkg::STAT_BAD;
                end else begin
                    wr    = 1'b1;
                    nbits = i_width[6:0];
                    vbits = (i_width == 8'd64) ? i_value
                          : (i_value & ((64'd1 << i_width[5:0]) - 64'd1));
                end
            end
            bpeg_pkg::MODE_UE: begin
                if (i_value > bpeg_pkg::UE_MAX_VALUE) begin
                    stat = bpeg_pkg::STAT_BAD;
                end else if (full) begin
                    stat = bpeg_pkg::STAT_FULL;
                end else begin
                    // leading zeros come from the zero-extension of the code
                    wr    = 1'b1;
                    nbits = 7'({ue_len, 1'b0}) - 7'd1;
                    vbits = {32'd0, code};
                end
            end
            bpeg_pkg::MODE_FLUSH: begin
                if (i_state.fill == 3'd0) begin
                    stat = bpeg_pkg::STAT_OK;
                end else if (full) begin
                    stat = bpeg_pkg::STAT_FULL;
                end else begin
                    // pad with zeros up to the byte boundary
                    wr    = 1'b1;
                    nbits = 7'd8 - {4'd0, i_state.fill};
                end
            end
            default: begin
                stat = bpeg_pkg::STAT_BAD;
            end
        endcase
    end

    // Bit window: pending bits on top, new bits right behind them
    assign tot       = {4'd0, i_state.fill} + nbits;
    assign tot_bytes = tot[6:3];
    assign trunc     = tot > {rem_c, 3'b000};
    assign emit      = trunc ? rem_c : tot_bytes;
    assign shamt     = 7'd72 - {4'd0, i_state.fill} - nbits;
    assign win       = {i_state.partial, 64'd0} | ({8'd0, vbits} << shamt);
    assign win_left  = win << {tot_bytes, 3'b000};

    // Next state and burst
    always_comb begin
        o_state = i_state;
        o_burst.bytes  = win[71:8];
        o_burst.count  = 4'd0;
        o_burst.status = stat;
        if (wr) begin
            o_burst.count  = emit;
            o_burst.status = trunc ? bpeg_pkg::STAT_FULL : bpeg_pkg::STAT_OK;
            o_state.done   = i_state.done + {28'd0, emit};
            if (trunc) begin
                o_state.partial = 8'd0;
                o_state.fill    = 3'd0;
            end else begin
                o_state.partial = win_left[71:64];
                o_state.fill    = tot[2:0];
            end
        end
    end

endmodule

// ----- design/bpeg_out.sv -----
// Output register: holds one word's byte burst and hands it out one byte per cycle unless stalled.
`timescale 1ns / 1ps

module bpeg_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  bpeg_pkg::t_burst i_burst,
    input  logic            i_stall,
    output logic            o_free,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic [1:0]      o_status,
    output logic            o_last
);

    logic              r_busy;
    logic [63:0]       r_bytes;
    logic [3:0]        r_cnt;
    bpeg_pkg::t_status r_status;
    logic              take;
    logic              last;

    assign last   = r_cnt <= 4'd1;
    assign take   = r_busy && !i_stall;
    assign o_free = !r_busy || (take && last);

    // Result fields; earlier bytes of a burst carry status ok
    assign o_valid      = r_busy;
    assign o_byte_valid = r_cnt != 4'd0;
    assign o_out_byte   = o_byte_valid ? r_bytes[63:56] : 8'd0;
    assign o_status     = last ? r_status : bpeg_pkg::STAT_OK;
    assign o_last       = last;

    // Busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (take && last) begin
            r_busy <= 1'b0;
        end
    end

    // Burst payload, shifted up by one byte per delivered byte
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes  <= i_burst.bytes;
            r_cnt    <= i_burst.count;
            r_status <= i_burst.status;
        end else if (take && !last) begin
            r_bytes <= {r_bytes[55:0], 8'd0};
            r_cnt   <= r_cnt - 4'd1;
        end
    end

endmodule

// ----- design/bit_packer_with_exp_golomb.sv -----
// Top level of the MSB-first bit packer with unsigned Exp-Golomb writes.
//
// Input channel (i_valid / o_stall): one word is a fixed write of 1..MAX_WIDTH
// bits, a ue write, or a flush of the partial byte. Output channel
// (o_valid / i_stall): completed bytes in order, each word ending with a
// result marked o_last that carries its status; a word that completes no
// byte gives one status-only result.
// An accepted word waits in the input register until the output register is
// free. Throughput: one word per cycle while each word yields one result and
// the receiver does not stall; a word that completes more bytes holds the
// output register, handing them out one byte per cycle while not stalled, and
// the input register takes one more word meanwhile. Byte capacity is written
// through i_wr_en / i_wr_data; the user must write it only while idle, the
// block itself does not enforce this. Reset clears the partial byte, fill
// count and byte count, empties both registers and sets the capacity to its
// maximum. While the receiver stalls the current result holds; once the
// input register is occupied as well, o_stall rises.
`timescale 1ns / 1ps

module bit_packer_with_exp_golomb #(
    parameter int MAX_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_value,
    input  logic [7:0]  i_width,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_wr_en,
    input  logic [31:0] i_wr_data
);

    logic                  r_in_valid;
    logic [1:0]            r_mode;
    logic [63:0]           r_value;
    logic [7:0]            r_width;
    logic [31:0]           r_cap;
    bpeg_pkg::t_pack_state r_state;
    bpeg_pkg::t_pack_state n_state;
    bpeg_pkg::t_burst      burst;
    logic                  out_free;
    logic                  accept;
    logic                  move;

    // Handshake: input word moves on when the output register frees up
    assign move    = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;
    assign accept  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_width <= i_width;
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 32'hFFFF_FFFF;
        end else if (i_wr_en) begin
            r_cap <= i_wr_data;
        end
    end

    // Packer state, updated as a word enters the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    bpeg_encode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_encode (
        .i_mode  (r_mode),
        .i_value (r_value),
        .i_width (r_width),
        .i_cap   (r_cap),
        .i_state (r_state),
        .o_state (n_state),
        .o_burst (burst)
    );

    bpeg_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (move),
        .i_burst      (burst),
        .i_stall      (i_stall),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
